[design/bsfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg: shared types and constants of the frame deframer
// register indexes, reset values and the structs passed between modules
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 11;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_FLAG_BYTE     = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ESCAPE_BYTE   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_XOR_MASK      = 2'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_FRAME_LEN = 2'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] FLAG_BYTE_RST     = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST   = 8'd125;
    localparam logic [BYTE_W-1:0] XOR_MASK_RST      = 8'd32;
    localparam logic [LEN_W-1:0]  MAX_FRAME_LEN_RST = 11'd600;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] xor_mask;
        logic [LEN_W-1:0]  max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic              in_frame;
        logic              escape_pending;
        logic              held_valid;
        logic [BYTE_W-1:0] held_value;
        logic [LEN_W-1:0]  kept_count;
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    localparam cfg_t CFG_RST = '{
        flag_byte:     FLAG_BYTE_RST,
        escape_byte:   ESCAPE_BYTE_RST,
        xor_mask:      XOR_MASK_RST,
        max_frame_len: MAX_FRAME_LEN_RST
    };

    localparam state_t STATE_RST = '{
        in_frame:       1'b0,
        escape_pending: 1'b0,
        held_valid:     1'b0,
        held_value:     '0,
        kept_count:     '0
    };

endpackage

[design/bsfd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_decode: per-byte destuffing decision
// classifies one byte against flag and escape, unescapes, limits length and
// produces the next deframer state plus at most one result
// ----------------------------------------------------------------------------
module bsfd_decode
(
    input  logic [bsfd_pkg::BYTE_W-1:0] rx_byte,
    input  bsfd_pkg::cfg_t              cfg,
    input  bsfd_pkg::state_t            state_cur,
    output bsfd_pkg::state_t            state_nxt,
    output bsfd_pkg::result_t           result
);

    logic                        is_flag;
    logic                        is_escape;
    logic                        has_room;
    logic [bsfd_pkg::BYTE_W-1:0] data_byte;

    assign is_flag   = (rx_byte == cfg.flag_byte);
    assign is_escape = (rx_byte == cfg.escape_byte);
    assign has_room  = (state_cur.kept_count < cfg.max_frame_len);
    assign data_byte = state_cur.escape_pending ? (rx_byte ^ cfg.xor_mask) : rx_byte;

    always_comb
    begin
        state_nxt = state_cur;
        result    = '{valid: 1'b0, data: state_cur.held_value, last: 1'b0};

        if (is_flag)
        begin
            // flag wins over a pending escape, closes any non-empty frame
            result.valid = state_cur.in_frame && state_cur.held_valid;
            result.last  = 1'b1;
            state_nxt    = bsfd_pkg::STATE_RST;
            state_nxt.in_frame = 1'b1;
        end
        else if (state_cur.in_frame)
        begin
            if (is_escape)
            begin
                state_nxt.escape_pending = 1'b1;
            end
            else
            begin
                state_nxt.escape_pending = 1'b0;
                if (has_room)
                begin
                    // release the held byte, hold the new one
                    result.valid         = state_cur.held_valid;
                    state_nxt.kept_count = state_cur.kept_count + 1'b1;
                    state_nxt.held_value = data_byte;
                    state_nxt.held_valid = 1'b1;
                end
            end
        end
    end

endmodule

[design/byte_stuffed_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit: byte-stuffed frame deframer
// removes flag and escape bytes from a received byte stream and emits the
// payload bytes of each frame with an end-of-frame marker
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------
//  in      | input     | in_valid / in_ready | rx_byte
//  out     | output    | out_valid/out_ready | out_byte, last
//  cfg     | input     | cfg_we (no wait)    | cfg_addr, cfg_wdata
//
//  one item per cycle while the consumer takes results or the result
//  register is free; an accepted item waits in the input register, and its
//  decode result is written to the result register as the item moves on
//  throughput is set by the single decode stage between the input register
//  and the result register; the frame state register is updated with it
//  in_ready drops only while the input register is full and the result
//  register holds an item the consumer does not take
//  reset clears the frame state, both valid flags and the configuration
//  registers to their default values; no clearing pass is needed
//
module byte_stuffed_frame_deframer_unit
(
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration write port
    input  logic                        cfg_we,
    input  logic [bsfd_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [bsfd_pkg::CFG_DW-1:0] cfg_wdata,

    // received byte stream
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bsfd_pkg::BYTE_W-1:0] rx_byte,

    // payload byte stream
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bsfd_pkg::BYTE_W-1:0] out_byte,
    output logic                        last
);

    // configuration registers
    bsfd_pkg::cfg_t              cfg_reg;

    // input register
    logic                        in_valid_reg;
    logic [bsfd_pkg::BYTE_W-1:0] in_byte_reg;

    // frame state
    bsfd_pkg::state_t            state_reg;
    bsfd_pkg::state_t            state_next;

    // result register
    logic                        out_valid_reg;
    logic [bsfd_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;

    bsfd_pkg::result_t           result;
    logic                        advance;

    // the held item moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

    // configuration writes: the user keeps them to an idle block, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bsfd_pkg::CFG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bsfd_pkg::REG_FLAG_BYTE:     cfg_reg.flag_byte     <= cfg_wdata[7:0];
                bsfd_pkg::REG_ESCAPE_BYTE:   cfg_reg.escape_byte   <= cfg_wdata[7:0];
                bsfd_pkg::REG_XOR_MASK:      cfg_reg.xor_mask      <= cfg_wdata[7:0];
                bsfd_pkg::REG_MAX_FRAME_LEN: cfg_reg.max_frame_len <= cfg_wdata;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // per-byte decision between the input and result registers
    bsfd_decode u_decode
    (
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result)
    );

    // control: valid flags and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= bsfd_pkg::STATE_RST;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= result.valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end

        if (advance && result.valid)
        begin
            out_byte_reg <= result.data;
            out_last_reg <= result.last;
        end
    end

endmodule

[design/bsfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_checker: port-level checks of the frame deframer
// watches the handshakes on the top level ports over time
// ----------------------------------------------------------------------------
module bsfd_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [bsfd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [bsfd_pkg::BYTE_W-1:0] out_byte,
    input  logic                        last
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    // a stalled input item holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(rx_byte))
        else $error("stalled input item changed");

    // a fresh result needs an accepted input item behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted item");

    // input backpressure only comes from a blocked output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output free");

    // register writes only while no item moves
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !in_valid && !out_valid)
        else $error("register written while items in flight");

endmodule

bind byte_stuffed_frame_deframer_unit bsfd_checker u_bsfd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);

[test/byte_stuffed_frame_deframer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit_tb: self-checking bench of the deframer
// drives raw link bytes through the valid/ready input, rebuilds the expected
// payload bytes with a local deframer model and checks every byte and end
// marker that leaves the block; a directed table comes first, then randomly
// built frames under several link settings and idling patterns
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_unit_tb;

    // cycles in which nothing moves on any port before the run is declared hung;
    // the longest legal quiet stretch is the receiver hold-off below
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    // margin to drain the input and result registers, also for items that leave no result
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int N_DIR          = 24;
    localparam int N_PHASES       = 8;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_NONE,   // no payload byte may come out of this item
        CHK_DATA,   // exactly the byte typed into the row
        CHK_MODEL   // whatever the local deframer model predicts
    } row_chk_t;

    typedef struct packed {
        logic [bsfd_pkg::BYTE_W-1:0] data;
        logic                        last;
    } payload_t;

    typedef struct packed {
        logic [bsfd_pkg::BYTE_W-1:0] rx;
        row_chk_t                    chk;
        logic [bsfd_pkg::BYTE_W-1:0] exp_byte;
        logic                        exp_last;
    } dir_row_t;

    // one block of random traffic under one link setting
    typedef struct packed {
        bsfd_pkg::cfg_t cfg;
        logic [6:0]     send_idle;
        logic [6:0]     recv_stall;
        logic [9:0]     items;
        logic           hold;
    } phase_t;

    // directed rows, all under the reset settings: flag 7e, escape 7d, mask 20
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{8'h00, CHK_NONE,  8'h00, 1'b0},   // before any flag: ignored
        '{8'hFF, CHK_NONE,  8'h00, 1'b0},
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},   // escape outside a frame: ignored
        '{8'h7E, CHK_NONE,  8'h00, 1'b0},   // first flag opens a frame
        '{8'h7E, CHK_NONE,  8'h00, 1'b0},   // empty frame emits nothing
        '{8'h00, CHK_NONE,  8'h00, 1'b0},   // held back
        '{8'hFF, CHK_DATA,  8'h00, 1'b0},
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},
        '{8'h5E, CHK_DATA,  8'hFF, 1'b0},   // unescapes to 7e
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},   // escape after escape stays armed
        '{8'h5D, CHK_DATA,  8'h7E, 1'b0},   // unescapes once to 7d
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},
        '{8'h7E, CHK_DATA,  8'h7D, 1'b1},   // flag after escape: flag wins
        '{8'hA5, CHK_NONE,  8'h00, 1'b0},   // escape must be cleared here
        '{8'h7E, CHK_DATA,  8'hA5, 1'b1},
        '{8'h5A, CHK_NONE,  8'h00, 1'b0},
        '{8'h7D, CHK_NONE,  8'h00, 1'b0},
        '{8'h20, CHK_DATA,  8'h5A, 1'b0},   // unescapes to 00
        '{8'h7E, CHK_DATA,  8'h00, 1'b1},
        '{8'h33, CHK_MODEL, 8'h00, 1'b0},
        '{8'h7D, CHK_MODEL, 8'h00, 1'b0},
        '{8'h7E, CHK_MODEL, 8'h00, 1'b0},
        '{8'hFF, CHK_MODEL, 8'h00, 1'b0}    // frame left open for the next phase
    };

    // link settings walk both extremes of every register; the frame left open
    // at the end of each phase sees the new settings mid-frame
    localparam phase_t PHASES [N_PHASES] = '{
        '{'{8'h7E, 8'h7D, 8'h20, 11'd600},  7'd0,  7'd0,  10'd45, 1'b0},
        '{'{8'h00, 8'hFF, 8'hFF, 11'd1},    7'd73, 7'd0,  10'd45, 1'b0},
        '{'{8'hFF, 8'h00, 8'h00, 11'd3},    7'd0,  7'd73, 10'd45, 1'b0},
        '{'{8'h7E, 8'h7E, 8'h20, 11'd5},    7'd26, 7'd26, 10'd40, 1'b0},
        '{'{8'h55, 8'hAA, 8'h01, 11'd0},    7'd0,  7'd0,  10'd25, 1'b0},
        '{'{8'hC0, 8'hDB, 8'h5A, 11'd2047}, 7'd0,  7'd0,  10'd40, 1'b0},
        '{'{8'h7E, 8'h7D, 8'h20, 11'd8},    7'd26, 7'd26, 10'd45, 1'b1},
        '{'{8'h7E, 8'h7D, 8'h20, 11'd4},    7'd73, 7'd26, 10'd35, 1'b0}
    };

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [bsfd_pkg::CFG_AW-1:0] cfg_addr  = '0;
    logic [bsfd_pkg::CFG_DW-1:0] cfg_wdata = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [bsfd_pkg::BYTE_W-1:0] rx_byte   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [bsfd_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    // model copy of the link settings and of the frame state
    bsfd_pkg::cfg_t   link_cfg = bsfd_pkg::CFG_RST;
    bsfd_pkg::state_t frame_st = bsfd_pkg::STATE_RST;
    payload_t         payload_q [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_off      = 1'b0;
    int  quiet_cycles   = 0;

    int  accepted_items = 0;
    int  framed_items   = 0;
    int  payloads_seen  = 0;
    int  frames_seen    = 0;
    int  mismatches     = 0;

    byte_stuffed_frame_deframer_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // deframer model: one raw link byte in, at most one payload byte out
    function automatic bit deframe_byte(input logic [bsfd_pkg::BYTE_W-1:0] rx,
                                        output payload_t res);
        logic [bsfd_pkg::BYTE_W-1:0] b;
        bit                          got;
        b   = rx;
        got = 1'b0;
        res = '0;
        if (rx == link_cfg.flag_byte)
        begin
            // a flag closes a non-empty frame, then opens the next one
            if (frame_st.in_frame && frame_st.held_valid)
            begin
                res.data = frame_st.held_value;
                res.last = 1'b1;
                got      = 1'b1;
            end
            frame_st.in_frame       = 1'b1;
            frame_st.escape_pending = 1'b0;
            frame_st.held_valid     = 1'b0;
            frame_st.held_value     = '0;
            frame_st.kept_count     = '0;
        end
        else if (frame_st.in_frame)
        begin
            if (rx == link_cfg.escape_byte)
            begin
                frame_st.escape_pending = 1'b1;
            end
            else
            begin
                if (frame_st.escape_pending)
                begin
                    b                       = rx ^ link_cfg.xor_mask;
                    frame_st.escape_pending = 1'b0;
                end
                // past the length limit the byte is dropped without a trace
                if (frame_st.kept_count < link_cfg.max_frame_len)
                begin
                    frame_st.kept_count = frame_st.kept_count + 1'b1;
                    if (frame_st.held_valid)
                    begin
                        res.data = frame_st.held_value;
                        res.last = 1'b0;
                        got      = 1'b1;
                    end
                    frame_st.held_value = b;
                    frame_st.held_valid = 1'b1;
                end
            end
        end
        return got;
    endfunction

    // offer one item, with random sender gaps, and return at the edge that takes it
    task automatic push_rx(input logic [bsfd_pkg::BYTE_W-1:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // send a link byte and book the payload byte it is owed
    task automatic feed_byte(input logic [bsfd_pkg::BYTE_W-1:0] b,
                             input row_chk_t chk = CHK_MODEL,
                             input payload_t typed = '0);
        payload_t predicted;
        bit       got;
        push_rx(b);
        accepted_items++;
        if (frame_st.in_frame || b == link_cfg.flag_byte)
            framed_items++;
        got = deframe_byte(b, predicted);
        if (chk == CHK_MODEL && got)
            payload_q = {payload_q, predicted};
        else if (chk == CHK_DATA)
            payload_q = {payload_q, typed};
    endtask

    // one payload byte, stuffed as a sender would, with the odd protocol slip
    task automatic send_payload_byte();
        logic [bsfd_pkg::BYTE_W-1:0] b;
        int                          pick;
        pick = $urandom_range(15);
        if (pick == 0)
            b = link_cfg.flag_byte;
        else if (pick == 1)
            b = link_cfg.escape_byte;
        else
            b = 8'($urandom_range(255));
        // stray escape in front of the byte, which then gets unescaped
        if (pick == 2)
            feed_byte(link_cfg.escape_byte);
        // mostly stuffed; an unstuffed flag or escape breaks the frame
        if ((b == link_cfg.flag_byte || b == link_cfg.escape_byte) && $urandom_range(7) != 0)
        begin
            feed_byte(link_cfg.escape_byte);
            feed_byte(b ^ link_cfg.xor_mask);
        end
        else
        begin
            feed_byte(b);
        end
    endtask

    // random frames with shared flags, sprinkled with line noise; ends mid-frame
    task automatic run_random(input int target);
        int first;
        int span;
        first = framed_items;
        while (framed_items - first < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, 6))
                    feed_byte(8'($urandom_range(255)));
            end
            else
            begin
                // small limits get frames that run past them
                span = (link_cfg.max_frame_len < 12) ? int'(link_cfg.max_frame_len) + 3 : 12;
                feed_byte(link_cfg.flag_byte);
                repeat ($urandom_range(0, span))
                    send_payload_byte();
            end
        end
        feed_byte(link_cfg.flag_byte);
        repeat ($urandom_range(3, 7))
            send_payload_byte();
    endtask

    // all four registers back to back, write enable kept high throughout
    task automatic load_link_cfg(input bsfd_pkg::cfg_t c);
        logic [bsfd_pkg::CFG_AW-1:0] idx [4];
        logic [bsfd_pkg::CFG_DW-1:0] val [4];
        idx[0] = bsfd_pkg::REG_FLAG_BYTE;
        idx[1] = bsfd_pkg::REG_ESCAPE_BYTE;
        idx[2] = bsfd_pkg::REG_XOR_MASK;
        idx[3] = bsfd_pkg::REG_MAX_FRAME_LEN;
        val[0] = bsfd_pkg::CFG_DW'(c.flag_byte);
        val[1] = bsfd_pkg::CFG_DW'(c.escape_byte);
        val[2] = bsfd_pkg::CFG_DW'(c.xor_mask);
        val[3] = bsfd_pkg::CFG_DW'(c.max_frame_len);
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_wdata <= val[k];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        link_cfg  = c;
    endtask

    // wait for every owed payload byte, then let bytes that owe nothing drain
    task automatic settle();
        while (payload_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // receiver: check each taken payload byte, then pick the next ready
    always @(posedge clk)
    begin : take_payload
        payload_t owed;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                payloads_seen++;
                if (last)
                    frames_seen++;
                if (payload_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("payload byte %02h last %0b came with nothing owed",
                                 out_byte, last);
                end
                else
                begin
                    owed = payload_q.pop_front();
                    if (out_byte !== owed.data || last !== owed.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"mismatch: expected byte %02h last %0b, ",
                                      "got byte %02h last %0b"},
                                     owed.data, owed.last, out_byte, last);
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles in which nothing moves on any port
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("byte_stuffed_frame_deframer_unit regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t row;
        phase_t   ph;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset settings, no idling
        for (int i = 0; i < N_DIR; i++)
        begin
            row = DIR_ROWS[i];
            feed_byte(row.rx, row.chk, '{row.exp_byte, row.exp_last});
        end
        in_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++)
        begin
            ph = PHASES[p];
            settle();
            load_link_cfg(ph.cfg);
            send_idle_pct   = int'(ph.send_idle);
            recv_stall_pct <= int'(ph.recv_stall);
            if (ph.hold)
            begin
                // receiver holds off while the sender keeps offering, so the
                // block fills up and drops in_ready
                fork
                    run_random(int'(ph.items));
                    begin
                        repeat (10)
                            @(posedge clk);
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES)
                            @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join
            end
            else
            begin
                run_random(int'(ph.items));
            end
            in_valid <= 1'b0;
        end

        // close the frame left open by the last phase
        settle();
        feed_byte(link_cfg.flag_byte);
        in_valid <= 1'b0;
        settle();

        if (payload_q.size() != 0)
        begin
            mismatches += payload_q.size();
            $display("%0d payload bytes never came out", payload_q.size());
        end

        $display("deframer run: %0d link bytes (%0d inside frames) under %0d link settings",
                 accepted_items, framed_items, N_PHASES + 1);
        $display("deframer run: %0d payload bytes in %0d closed frames, %0d mismatches",
                 payloads_seen, frames_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("byte_stuffed_frame_deframer_unit regression: pass");
        end
        else
        begin
            $display("byte_stuffed_frame_deframer_unit regression: fail");
        end
        $finish;
    end

endmodule
